// ===== src/dbd_pkg.sv =====
`timescale 1ns / 1ps

package dbd_pkg;

	localparam int MAX_REGIONS_DEF = 8;
	localparam int SIZE_BITS_DEF   = 13;

	localparam int CORNER_W = 19;
	localparam int FRAC_BITS = 16;
	localparam int HALF_Q16 = 1 << (FRAC_BITS - 1);
	localparam int FRAC_MASK = (1 << FRAC_BITS) - 1;

	localparam int IN_DATA_W  = 152;
	localparam int OUT_DATA_W = 104;
	localparam int THR_W = 17;
	localparam int ROI_W = 4;
	localparam logic [THR_W-1:0] THR_RESET = 17'd32768;
	localparam logic [ROI_W-1:0] ROI_RESET = 4'd1;

	typedef enum logic {
		OP_LOAD     = 1'b0,
		OP_PROPOSAL = 1'b1
	} op_t;

	typedef enum logic {
		CFG_THRESHOLD = 1'b0,
		CFG_ROI_COUNT = 1'b1
	} cfg_idx_t;

	function automatic logic [14:0] clamp_min(input logic signed [31:0] v);
		logic [14:0] r;
		if (v < 32'sd0) begin
			r = '0;
		end else if (v > 32'sd32767) begin
			r = 15'h7FFF;
		end else begin
			r = v[14:0];
		end
		return r;
	endfunction

	function automatic logic [15:0] clamp_max(input logic signed [31:0] v,
			input logic signed [31:0] lim);
		logic signed [31:0] m;
		logic [15:0] r;
		m = (v > lim) ? lim : v;
		if (m > 32'sd32767) begin
			r = 16'h7FFF;
		end else if (m < -32'sd32768) begin
			r = 16'h8000;
		end else begin
			r = m[15:0];
		end
		return r;
	endfunction

endpackage

// ===== src/detection_box_decoder.sv =====
`timescale 1ns / 1ps
// A kept proposal passes the stage registers v1_s1, v2_s2 and out_v_q in order
// before m_tvalid rises; its output transfer then waits for m_tready.
// Throughput: one item per cycle while m_tready does not stall the output;
// the size table is read in the transfer cycle. Load items and dropped proposals
// produce no output transfer. Reset clears the stop flag, the table entries (read
// as zero) and sets the threshold to 32768 and the region count to one.
module detection_box_decoder #(
	parameter int MAX_REGIONS = dbd_pkg::MAX_REGIONS_DEF,
	parameter int SIZE_BITS   = dbd_pkg::SIZE_BITS_DEF
) (
	input  logic                               clk,
	input  logic                               arst_n,
	input  logic                               s_tvalid,
	output logic                               s_tready,
	// roi_index, class_label, confidence, norm_x_min, norm_y_min, norm_x_max,
	// norm_y_max, region_width, region_height, zero pad.
	input  logic [dbd_pkg::IN_DATA_W-1:0]      s_tdata,
	// operation, first_of_blob.
	input  logic [1:0]                         s_tuser,
	output logic                               m_tvalid,
	input  logic                               m_tready,
	// box_image, box_label, box_confidence, pix_x_min, pix_y_min, pix_x_max,
	// pix_y_max, zero pad.
	output logic [dbd_pkg::OUT_DATA_W-1:0]     m_tdata,
	input  logic                               cfg_we,
	input  logic                               cfg_index,
	input  logic [dbd_pkg::THR_W-1:0]          cfg_data
);

	localparam int AW = (MAX_REGIONS > 1) ? $clog2(MAX_REGIONS) : 1;
	localparam int PW = dbd_pkg::CORNER_W + SIZE_BITS + 1;
	localparam int QW = PW + 1 - dbd_pkg::FRAC_BITS;
	localparam int CW = dbd_pkg::CORNER_W;

	logic [dbd_pkg::THR_W-1:0] thr_q;
	logic [dbd_pkg::ROI_W-1:0] roi_q;
	logic stopped_q;

	logic signed [15:0] in_id;
	logic [15:0] in_label;
	logic [16:0] in_conf;
	logic signed [CW-1:0] in_xmn, in_ymn, in_xmx, in_ymx;
	logic [12:0] in_w, in_h;
	dbd_pkg::op_t in_op;
	logic in_first;

	logic accept, slot_ok, id_ok, stop_eff, keep, tbl_we;
	logic en1, en2, en3;

	logic v1_s1, v2_s2;
	logic [2:0] img_s1, img_s2;
	logic [15:0] label_s1, label_s2;
	logic [16:0] conf_s1, conf_s2;
	logic signed [CW-1:0] xmn_s1, ymn_s1, xmx_s1, ymx_s1;
	logic [SIZE_BITS-1:0] w_tbl, h_tbl, w_s2, h_s2;
	logic signed [QW-1:0] xmn_px, ymn_px, xmx_px, ymx_px;
	logic signed [31:0] w_x, h_x;

	logic out_v_q;
	logic [dbd_pkg::OUT_DATA_W-1:0] out_q;

	assign in_id    = $signed(s_tdata[15:0]);
	assign in_label = s_tdata[31:16];
	assign in_conf  = s_tdata[48:32];
	assign in_xmn   = $signed(s_tdata[67:49]);
	assign in_ymn   = $signed(s_tdata[86:68]);
	assign in_xmx   = $signed(s_tdata[105:87]);
	assign in_ymx   = $signed(s_tdata[124:106]);
	assign in_w     = s_tdata[137:125];
	assign in_h     = s_tdata[150:138];
	assign in_op    = dbd_pkg::op_t'(s_tuser[0]);
	assign in_first = s_tuser[1];

	assign en3 = !out_v_q || m_tready;
	assign en2 = !v2_s2 || en3;
	assign en1 = !v1_s1 || en2;
	assign s_tready = en1;
	assign accept = s_tvalid && s_tready;

	always_comb begin
		slot_ok  = !in_id[15] && (in_id[14:0] < 15'(MAX_REGIONS));
		id_ok    = slot_ok && (in_id[14:0] < 15'(roi_q));
		stop_eff = stopped_q && !in_first;
		keep     = accept && (in_op == dbd_pkg::OP_PROPOSAL) && !stop_eff && id_ok
			&& (in_conf >= thr_q);
		tbl_we   = accept && (in_op == dbd_pkg::OP_LOAD) && slot_ok;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			thr_q     <= dbd_pkg::THR_RESET;
			roi_q     <= dbd_pkg::ROI_RESET;
			stopped_q <= 1'b0;
			v1_s1     <= 1'b0;
			v2_s2     <= 1'b0;
			out_v_q   <= 1'b0;
		end else begin
			if (cfg_we) begin
				case (dbd_pkg::cfg_idx_t'(cfg_index))
					dbd_pkg::CFG_THRESHOLD: thr_q <= cfg_data;
					dbd_pkg::CFG_ROI_COUNT: roi_q <= cfg_data[dbd_pkg::ROI_W-1:0];
					default: ;
				endcase
			end
			if (accept && (in_op == dbd_pkg::OP_PROPOSAL)) begin
				stopped_q <= stop_eff || !id_ok;
			end
			if (en1) begin
				v1_s1 <= keep;
			end
			if (en2) begin
				v2_s2 <= v1_s1;
			end
			if (en3) begin
				out_v_q <= v2_s2;
			end
		end
	end

	dbd_size_table #(
		.DEPTH(MAX_REGIONS),
		.AW(AW),
		.DW(SIZE_BITS)
	) u_table (
		.clk(clk),
		.arst_n(arst_n),
		.we(tbl_we),
		.waddr(in_id[AW-1:0]),
		.wdata_w(SIZE_BITS'(in_w)),
		.wdata_h(SIZE_BITS'(in_h)),
		.re(keep),
		.raddr(in_id[AW-1:0]),
		.rdata_w(w_tbl),
		.rdata_h(h_tbl)
	);

	always_ff @(posedge clk) begin
		if (keep) begin
			img_s1   <= in_id[2:0];
			label_s1 <= in_label;
			conf_s1  <= in_conf;
			xmn_s1   <= in_xmn;
			ymn_s1   <= in_ymn;
			xmx_s1   <= in_xmx;
			ymx_s1   <= in_ymx;
		end
		if (en2 && v1_s1) begin
			img_s2   <= img_s1;
			label_s2 <= label_s1;
			conf_s2  <= conf_s1;
			w_s2     <= w_tbl;
			h_s2     <= h_tbl;
		end
	end

	dbd_corner #(.SIZE_BITS(SIZE_BITS)) u_xmn (
		.clk(clk), .en(en2 && v1_s1), .corner(xmn_s1), .size(w_tbl), .pixel(xmn_px)
	);
	dbd_corner #(.SIZE_BITS(SIZE_BITS)) u_ymn (
		.clk(clk), .en(en2 && v1_s1), .corner(ymn_s1), .size(h_tbl), .pixel(ymn_px)
	);
	dbd_corner #(.SIZE_BITS(SIZE_BITS)) u_xmx (
		.clk(clk), .en(en2 && v1_s1), .corner(xmx_s1), .size(w_tbl), .pixel(xmx_px)
	);
	dbd_corner #(.SIZE_BITS(SIZE_BITS)) u_ymx (
		.clk(clk), .en(en2 && v1_s1), .corner(ymx_s1), .size(h_tbl), .pixel(ymx_px)
	);

	assign w_x = 32'(w_s2);
	assign h_x = 32'(h_s2);

	always_ff @(posedge clk) begin
		if (en3 && v2_s2) begin
			out_q <= {
				6'd0,
				dbd_pkg::clamp_max(32'(ymx_px), h_x),
				dbd_pkg::clamp_max(32'(xmx_px), w_x),
				dbd_pkg::clamp_min(32'(ymn_px)),
				dbd_pkg::clamp_min(32'(xmn_px)),
				conf_s2,
				label_s2,
				img_s2
			};
		end
	end

	assign m_tvalid = out_v_q;
	assign m_tdata  = out_q;

endmodule

// ===== src/dbd_size_table.sv =====
`timescale 1ns / 1ps

module dbd_size_table #(
	parameter int DEPTH = dbd_pkg::MAX_REGIONS_DEF,
	parameter int AW    = 3,
	parameter int DW    = dbd_pkg::SIZE_BITS_DEF
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          we,
	input  logic [AW-1:0] waddr,
	input  logic [DW-1:0] wdata_w,
	input  logic [DW-1:0] wdata_h,
	input  logic          re,
	input  logic [AW-1:0] raddr,
	output logic [DW-1:0] rdata_w,
	output logic [DW-1:0] rdata_h
);

	logic [2*DW-1:0] mem [DEPTH];
	logic [DEPTH-1:0] written_q;
	logic [2*DW-1:0] rd_s1;
	logic rd_ok_s1;

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= {wdata_h, wdata_w};
		end
		if (re) begin
			rd_s1    <= mem[raddr];
			rd_ok_s1 <= written_q[raddr];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			written_q <= '0;
		end else if (we) begin
			written_q[waddr] <= 1'b1;
		end
	end

	assign rdata_w = rd_ok_s1 ? rd_s1[DW-1:0] : '0;
	assign rdata_h = rd_ok_s1 ? rd_s1[2*DW-1:DW] : '0;

endmodule

// ===== src/dbd_corner.sv =====
`timescale 1ns / 1ps

module dbd_corner #(
	parameter int SIZE_BITS = dbd_pkg::SIZE_BITS_DEF,
	parameter int PW = dbd_pkg::CORNER_W + SIZE_BITS + 1,
	parameter int QW = PW + 1 - dbd_pkg::FRAC_BITS
) (
	input  logic                                 clk,
	input  logic                                 en,
	input  logic signed [dbd_pkg::CORNER_W-1:0]  corner,
	input  logic        [SIZE_BITS-1:0]          size,
	output logic signed [QW-1:0]                 pixel
);

	logic signed [PW-1:0] prod_s2;
	logic [PW:0] t;
	logic [PW:0] u;

	always_ff @(posedge clk) begin
		if (en) begin
			prod_s2 <= corner * $signed({1'b0, size});
		end
	end

	// Round half up, then truncate toward zero by biasing negative sums.
	always_comb begin
		t = {prod_s2[PW-1], prod_s2} + (PW+1)'(dbd_pkg::HALF_Q16);
		u = t + (t[PW] ? (PW+1)'(dbd_pkg::FRAC_MASK) : '0);
	end

	assign pixel = $signed(u[PW:dbd_pkg::FRAC_BITS]);

endmodule

// ===== tb/dbd_box_checker.sv =====
`timescale 1ns / 1ps

module dbd_box_checker (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           s_tvalid,
	input  logic                           s_tready,
	// roi_index, class_label, confidence, norm_x_min, norm_y_min, norm_x_max,
	// norm_y_max, region_width, region_height, zero pad.
	input  logic [dbd_pkg::IN_DATA_W-1:0]  s_tdata,
	// operation, first_of_blob.
	input  logic [1:0]                     s_tuser,
	input  logic                           m_tvalid,
	input  logic                           m_tready,
	// box_image, box_label, box_confidence, pix_x_min, pix_y_min, pix_x_max,
	// pix_y_max, zero pad.
	input  logic [dbd_pkg::OUT_DATA_W-1:0] m_tdata,
	input  logic                           cfg_we,
	input  logic                           cfg_index,
	input  logic [dbd_pkg::THR_W-1:0]      cfg_data,
	output int                             errors,
	output int                             pending,
	output int                             boxes
);

	typedef struct packed {
		logic [2:0]         image;
		logic signed [15:0] label;
		logic [16:0]        conf;
		logic [14:0]        x0;
		logic [14:0]        y0;
		logic signed [15:0] x1;
		logic signed [15:0] y1;
	} box_t;

	box_t        box_queue[$];
	logic [16:0] thr;
	logic [3:0]  roi;
	logic [12:0] width_mem[dbd_pkg::MAX_REGIONS_DEF];
	logic [12:0] height_mem[dbd_pkg::MAX_REGIONS_DEF];
	logic        halted;

	// Scales a signed Q3.16 corner by a pixel size and rounds half up, truncating
	// toward zero as the block does.
	function automatic longint scale_round(logic [18:0] corner, longint size);
		longint t;
		t = longint'($signed(corner)) * size + dbd_pkg::HALF_Q16;
		return t / 65536;
	endfunction

	function automatic longint sat(longint v, longint lo, longint hi);
		if (v < lo) begin
			return lo;
		end
		if (v > hi) begin
			return hi;
		end
		return v;
	endfunction

	always @(posedge clk or negedge arst_n) begin
		int     sid;
		longint sw;
		longint sh;
		longint v;
		box_t   want;
		box_t   got;
		if (!arst_n) begin
			thr = dbd_pkg::THR_RESET;
			roi = dbd_pkg::ROI_RESET;
			halted = 1'b0;
			for (int i = 0; i < dbd_pkg::MAX_REGIONS_DEF; i++) begin
				width_mem[i] = '0;
				height_mem[i] = '0;
			end
			box_queue.delete();
			pending <= 0;
		end else begin
			if (cfg_we) begin
				case (dbd_pkg::cfg_idx_t'(cfg_index))
					dbd_pkg::CFG_THRESHOLD: begin
						thr = cfg_data;
					end
					dbd_pkg::CFG_ROI_COUNT: begin
						roi = cfg_data[3:0];
					end
					default: begin
					end
				endcase
			end

			if (s_tvalid && s_tready) begin
				sid = int'($signed(s_tdata[15:0]));
				if (dbd_pkg::op_t'(s_tuser[0]) == dbd_pkg::OP_LOAD) begin
					if (sid >= 0 && sid < dbd_pkg::MAX_REGIONS_DEF) begin
						width_mem[sid] = s_tdata[137:125];
						height_mem[sid] = s_tdata[150:138];
					end
				end else begin
					if (s_tuser[1]) begin
						halted = 1'b0;
					end
					if (!halted) begin
						if (sid < 0 || sid >= int'(roi) || sid >= dbd_pkg::MAX_REGIONS_DEF) begin
							halted = 1'b1;
						end else if (s_tdata[48:32] >= thr) begin
							sw = width_mem[sid];
							sh = height_mem[sid];
							want.image = sid[2:0];
							want.label = s_tdata[31:16];
							want.conf = s_tdata[48:32];
							v = sat(scale_round(s_tdata[67:49], sw), 0, 32767);
							want.x0 = v[14:0];
							v = sat(scale_round(s_tdata[86:68], sh), 0, 32767);
							want.y0 = v[14:0];
							v = sat(sat(scale_round(s_tdata[105:87], sw), -65536, sw),
								-32768, 32767);
							want.x1 = v[15:0];
							v = sat(sat(scale_round(s_tdata[124:106], sh), -65536, sh),
								-32768, 32767);
							want.y1 = v[15:0];
							box_queue.push_back(want);
						end
					end
				end
			end

			if (m_tvalid && m_tready) begin
				got.image = m_tdata[2:0];
				got.label = m_tdata[18:3];
				got.conf = m_tdata[35:19];
				got.x0 = m_tdata[50:36];
				got.y0 = m_tdata[65:51];
				got.x1 = m_tdata[81:66];
				got.y1 = m_tdata[97:82];
				boxes++;
				if (box_queue.size() == 0) begin
					errors++;
					if (errors <= 10) begin
						$display("%0t: unexpected box transfer image=%0d label=%0d conf=%0d",
							$realtime, got.image, got.label, got.conf);
					end
				end else begin
					want = box_queue.pop_front();
					if (got.image != want.image || got.label != want.label ||
							got.conf != want.conf || got.x0 != want.x0 ||
							got.y0 != want.y0 || got.x1 != want.x1 || got.y1 != want.y1) begin
						errors++;
						if (errors <= 10) begin
							$display("%0t: box mismatch, expected %0d %0d %0d (%0d,%0d)-(%0d,%0d)",
								$realtime, want.image, want.label, want.conf,
								want.x0, want.y0, want.x1, want.y1);
							$display("%0t: box mismatch, actual   %0d %0d %0d (%0d,%0d)-(%0d,%0d)",
								$realtime, got.image, got.label, got.conf,
								got.x0, got.y0, got.x1, got.y1);
						end
					end
				end
			end

			pending <= box_queue.size();
		end
	end

endmodule

// ===== tb/tb_detection_box_decoder.sv =====
`timescale 1ns / 1ps

module tb_detection_box_decoder;

	localparam int SEG_ITEMS = 210;
	localparam int DRAIN_CYCLES = 8;

	logic                           clk = 1'b0;
	logic                           arst_n = 1'b0;
	logic                           s_tvalid = 1'b0;
	logic                           s_tready;
	logic [dbd_pkg::IN_DATA_W-1:0]  s_tdata = '0;
	logic [1:0]                     s_tuser = '0;
	logic                           m_tvalid;
	logic                           m_tready = 1'b0;
	logic [dbd_pkg::OUT_DATA_W-1:0] m_tdata;
	logic                           cfg_we = 1'b0;
	logic                           cfg_index = 1'b0;
	logic [dbd_pkg::THR_W-1:0]      cfg_data = '0;

	int errors;
	int pending;
	int boxes;
	int tx_idle = 25;
	int rx_idle = 68;
	int cur_thr = 32768;
	int cur_roi = 1;
	int n_loads = 0;
	int n_props = 0;
	int thr_plan[9] = '{0, 131071, 32768, -1, 1, -1, 65536, -1, 32768};
	int roi_plan[9] = '{8, 1, 8, 15, 0, 3, 8, 5, 2};

	always begin
		#2 clk = 1'b1;
		#2 clk = 1'b0;
	end

	detection_box_decoder uut (
		.clk(clk),
		.arst_n(arst_n),
		.s_tvalid(s_tvalid),
		.s_tready(s_tready),
		.s_tdata(s_tdata),
		.s_tuser(s_tuser),
		.m_tvalid(m_tvalid),
		.m_tready(m_tready),
		.m_tdata(m_tdata),
		.cfg_we(cfg_we),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data)
	);

	dbd_box_checker u_checker (
		.clk(clk),
		.arst_n(arst_n),
		.s_tvalid(s_tvalid),
		.s_tready(s_tready),
		.s_tdata(s_tdata),
		.s_tuser(s_tuser),
		.m_tvalid(m_tvalid),
		.m_tready(m_tready),
		.m_tdata(m_tdata),
		.cfg_we(cfg_we),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data),
		.errors(errors),
		.pending(pending),
		.boxes(boxes)
	);

	always @(posedge clk) begin
		m_tready <= ($urandom_range(99) >= rx_idle);
	end

	initial begin
		#2_000_000;
		$display("Timeout with %0d boxes still outstanding.", pending);
		$display("RESULT: ERROR");
		$finish;
	end

	task automatic configure(int thr, int roi);
		cfg_we <= 1'b1;
		cfg_index <= dbd_pkg::CFG_THRESHOLD;
		cfg_data <= dbd_pkg::THR_W'(thr);
		@(posedge clk);
		cfg_index <= dbd_pkg::CFG_ROI_COUNT;
		cfg_data <= dbd_pkg::THR_W'(roi);
		@(posedge clk);
		cfg_we <= 1'b0;
		@(posedge clk);
		cur_thr = thr;
		cur_roi = roi;
	endtask

	task automatic send(dbd_pkg::op_t op, logic first, logic [15:0] id, logic [15:0] label,
			logic [16:0] conf, logic [18:0] x0, logic [18:0] y0, logic [18:0] x1,
			logic [18:0] y1, logic [12:0] w, logic [12:0] h);
		int gap;
		gap = 0;
		while ($urandom_range(99) < tx_idle && gap < 40) begin
			gap++;
		end
		if (gap > 0) begin
			s_tvalid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tuser <= {first, op};
		s_tdata <= {1'b0, h, w, y1, x1, y0, x0, conf, label, id};
		@(posedge clk);
		while (!s_tready) begin
			@(posedge clk);
		end
		if (op == dbd_pkg::OP_LOAD) begin
			n_loads++;
		end else begin
			n_props++;
		end
	endtask

	task automatic load(logic [15:0] slot, logic [12:0] w, logic [12:0] h);
		send(dbd_pkg::OP_LOAD, 1'b0, slot, 16'h0, 17'h0, 19'h0, 19'h0, 19'h0, 19'h0, w, h);
	endtask

	task automatic propose(logic first, logic [15:0] id, logic [15:0] label,
			logic [16:0] conf, logic [18:0] x0, logic [18:0] y0, logic [18:0] x1,
			logic [18:0] y1);
		send(dbd_pkg::OP_PROPOSAL, first, id, label, conf, x0, y0, x1, y1, 13'h0, 13'h0);
	endtask

	// Waits until every predicted box has been transferred and the pipeline
	// has had time to flush items that produce no box.
	task automatic settle();
		s_tvalid <= 1'b0;
		@(posedge clk);
		while (pending != 0) begin
			@(posedge clk);
		end
		repeat (DRAIN_CYCLES) @(posedge clk);
	endtask

	function automatic logic [18:0] rand_corner();
		logic [18:0] c;
		case ($urandom_range(9))
			0, 1: begin
				c = 19'($urandom());
			end
			2: begin
				case ($urandom_range(4))
					0: c = 19'h3FFFF;
					1: c = 19'h40000;
					2: c = 19'h00000;
					3: c = 19'h10000;
					default: c = 19'h7FFFF;
				endcase
			end
			default: begin
				c = 19'($urandom_range(65536));
			end
		endcase
		return c;
	endfunction

	function automatic logic [12:0] rand_size();
		logic [12:0] s;
		case ($urandom_range(9))
			0: s = 13'd0;
			1: s = 13'h1FFF;
			default: s = 13'($urandom());
		endcase
		return s;
	endfunction

	task automatic random_item();
		logic [15:0]   id;
		logic [15:0]   label;
		logic [16:0]   conf;
		logic          first;
		dbd_pkg::op_t  op;
		int            lim;
		int            c;
		lim = (cur_roi > dbd_pkg::MAX_REGIONS_DEF) ? dbd_pkg::MAX_REGIONS_DEF : cur_roi;
		label = 16'($urandom());
		op = ($urandom_range(99) < 12) ? dbd_pkg::OP_LOAD : dbd_pkg::OP_PROPOSAL;
		first = ($urandom_range(99) < 15);
		if (op == dbd_pkg::OP_LOAD) begin
			id = ($urandom_range(99) < 85) ? 16'($urandom_range(7)) : 16'($urandom());
		end else if ($urandom_range(99) < 94) begin
			id = (lim > 0) ? 16'($urandom_range(lim - 1)) : 16'h0;
		end else begin
			case ($urandom_range(5))
				0: id = 16'($urandom());
				1: id = 16'hFFFF;
				2: id = 16'(cur_roi);
				3: id = 16'(dbd_pkg::MAX_REGIONS_DEF);
				4: id = 16'h8000;
				default: id = 16'h7FFF;
			endcase
		end
		case ($urandom_range(9))
			0, 1, 2, 3: begin
				c = $urandom_range(131071);
			end
			4: begin
				c = cur_thr - 1 - int'($urandom_range(2));
				if (c < 0) begin
					c = 0;
				end
			end
			default: begin
				c = cur_thr + int'($urandom_range(3000));
				if (c > 131071) begin
					c = 131071;
				end
			end
		endcase
		conf = c[16:0];
		send(op, first, id, label, conf, rand_corner(), rand_corner(), rand_corner(),
			rand_corner(), rand_size(), rand_size());
	endtask

	initial begin
		int thr;
		repeat (6) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		configure(32768, 8);
		load(16'd0, 13'd8191, 13'd8191);
		load(16'd1, 13'd640, 13'd480);
		load(16'd7, 13'd1, 13'd1);
		load(16'hFFFF, 13'd100, 13'd100);
		load(16'd8, 13'd200, 13'd200);
		propose(1'b1, 16'd0, 16'h7FFF, 17'h1FFFF, 19'h3FFFF, 19'h3FFFF, 19'h3FFFF, 19'h3FFFF);
		propose(1'b0, 16'd0, 16'h8000, 17'd32768, 19'h40000, 19'h40000, 19'h40000, 19'h40000);
		propose(1'b0, 16'd1, 16'd5, 17'd32767, 19'd100, 19'd100, 19'd200, 19'd200);
		propose(1'b0, 16'd1, 16'd6, 17'd32768, 19'd32768, 19'd32768, 19'd65536, 19'd65536);
		propose(1'b0, 16'd1, 16'hFFFF, 17'd40000, 19'h7FFFF, 19'h7FFCC, 19'd51, 19'd52);
		propose(1'b0, 16'd6, 16'd9, 17'h1FFFF, 19'd30000, 19'd30000, 19'd60000, 19'd60000);
		propose(1'b0, 16'd8, 16'd1, 17'h1FFFF, 19'd1000, 19'd1000, 19'd2000, 19'd2000);
		propose(1'b0, 16'd0, 16'd2, 17'h1FFFF, 19'd1000, 19'd1000, 19'd2000, 19'd2000);
		load(16'd2, 13'd1920, 13'd1080);
		propose(1'b1, 16'd2, 16'd3, 17'd50000, 19'd13107, 19'd6553, 19'd52428, 19'd58981);
		propose(1'b0, 16'hFFFF, 16'd4, 17'd50000, 19'd100, 19'd100, 19'd200, 19'd200);
		propose(1'b0, 16'd1, 16'd4, 17'd50000, 19'd100, 19'd100, 19'd200, 19'd200);
		propose(1'b1, 16'h8000, 16'd4, 17'd50000, 19'd100, 19'd100, 19'd200, 19'd200);
		propose(1'b1, 16'h7FFF, 16'd4, 17'd50000, 19'd100, 19'd100, 19'd200, 19'd200);
		propose(1'b1, 16'd7, 16'd5, 17'd0, 19'd65535, 19'd65535, 19'd65535, 19'd65535);
		propose(1'b0, 16'd7, 16'd5, 17'h1FFFF, 19'd32767, 19'd32768, 19'd65535, 19'd98304);
		propose(1'b0, 16'd0, 16'd5, 17'd0, 19'd100, 19'd100, 19'd200, 19'd200);
		settle();

		for (int seg = 0; seg < 9; seg++) begin
			if (seg < 3) begin
				tx_idle = 25;
				rx_idle = 68;
			end else if (seg < 6) begin
				tx_idle = 68;
				rx_idle = 25;
			end else begin
				tx_idle = 0;
				rx_idle = 0;
			end
			thr = (thr_plan[seg] < 0) ? int'($urandom_range(131071)) : thr_plan[seg];
			configure(thr, roi_plan[seg]);
			repeat (SEG_ITEMS) random_item();
			settle();
		end

		repeat (20) @(posedge clk);
		$display("Sent %0d items: %0d region loads and %0d proposals; %0d boxes checked.",
			n_loads + n_props, n_loads, n_props, boxes);
		$display("Ten register settings, region counts 0 to 15, thresholds 0 to 131071, %s",
			"three idle profiles; mismatches found above.");
		if (errors == 0 && pending == 0) begin
			$display("RESULT: OK");
		end else begin
			$display("Failures: %0d mismatches, %0d boxes missing.", errors, pending);
			$display("RESULT: ERROR");
		end
		$finish;
	end

endmodule
